[rtl/core/tpt_pkg.sv]
// ----------------------------------------------------------------------------
// TLB translator package
// This package holds the sizes, types and helper functions that the TLB
// translator modules share.
// ----------------------------------------------------------------------------
package tpt_pkg;

	localparam int TLB_ENTRIES = 16;
	localparam int PAGE_COUNT  = 256;
	localparam int FRAME_COUNT = 256;
	localparam int OFFSET_BITS = 8;
	localparam int ADDR_W      = 16;
	localparam int COUNT_W     = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam int PAGE_W    = $clog2(PAGE_COUNT);
	localparam int FRAME_W   = $clog2(FRAME_COUNT);
	localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [PAGE_W-1:0]      page_t;
	typedef logic [FRAME_W-1:0]     frame_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [TLB_IDX_W-1:0]   tlb_idx_t;
	typedef logic [COUNT_W-1:0]     count_t;

	typedef enum logic [1:0] {
		OUT_TLB_HIT   = 2'd0,
		OUT_TABLE_HIT = 2'd1,
		OUT_FAULT     = 2'd2
	} outcome_t;

	typedef struct packed {
		page_t   page;
		offset_t offset;
		logic    tlb_hit;
		frame_t  frame;
	} lookup_t;

	typedef struct packed {
		logic   done;
		logic   fill_en;
		page_t  page;
		frame_t frame;
	} back_stat_t;

	function automatic page_t page_of(input addr_t addr);
		logic [ADDR_W+PAGE_W-1:0] vpn;
		vpn = {{PAGE_W{1'b0}}, addr} >> OFFSET_BITS;
		return vpn[PAGE_W-1:0];
	endfunction

	function automatic offset_t offset_of(input addr_t addr);
		return addr[OFFSET_BITS-1:0];
	endfunction

	function automatic addr_t phys_addr(input frame_t frame, input offset_t offset);
		logic [ADDR_W+FRAME_W+OFFSET_BITS-1:0] wide;
		wide = {{ADDR_W{1'b0}}, frame, offset};
		return wide[ADDR_W-1:0];
	endfunction

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

endpackage

[rtl/core/tpt_queue.sv]
// ----------------------------------------------------------------------------
// TLB translator lookup queue
// A short first-in first-out queue that carries classified lookups from the
// front part to the back part.
// ----------------------------------------------------------------------------
module tpt_queue
	import tpt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  lookup_t push_data,
	input  logic    pop,
	output lookup_t pop_data,
	output logic    empty
);

	lookup_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               full;
	logic               do_push;
	logic               do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/tpt_front.sv]
// ----------------------------------------------------------------------------
// TLB translator front part
// Accepts logical addresses, searches the fully associative TLB and hands the
// classified lookup to the queue. Holds the TLB and its FIFO replace pointer.
// ----------------------------------------------------------------------------
module tpt_front
	import tpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  addr_t      logical_address,
	output logic       push,
	output lookup_t    push_data,
	input  back_stat_t stat
);

	page_t    tag_q   [TLB_ENTRIES];
	frame_t   frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] valid_q;
	tlb_idx_t replace_q;
	logic     busy_q;
	logic     hit;
	frame_t   hit_frame;
	page_t    page;

	assign busy = busy_q;
	assign push = start && !busy_q;
	assign page = page_of(logical_address);

	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == page) begin
				hit       = 1'b1;
				hit_frame = frame_q[i];
			end
		end
	end

	always_comb begin
		push_data.page    = page;
		push_data.offset  = offset_of(logical_address);
		push_data.tlb_hit = hit;
		push_data.frame   = hit_frame;
	end

	always_ff @(posedge clk) begin
		if (stat.fill_en) begin
			tag_q[replace_q]   <= stat.page;
			frame_q[replace_q] <= stat.frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			replace_q <= '0;
			busy_q    <= 1'b0;
		end else begin
			if (stat.fill_en) begin
				valid_q[replace_q] <= 1'b1;
				replace_q <= (replace_q == tlb_idx_t'(TLB_ENTRIES - 1)) ?
					'0 : replace_q + tlb_idx_t'(1);
			end
			if (push) begin
				busy_q <= 1'b1;
			end else if (stat.done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/tpt_back.sv]
// ----------------------------------------------------------------------------
// TLB translator back part
// Reads the page table, allocates frames on a page fault, keeps the running
// counts and drives the result beat. Reports TLB refills to the front part.
// ----------------------------------------------------------------------------
module tpt_back
	import tpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lookup_t    pop_data,
	input  logic       empty,
	output logic       pop,
	output back_stat_t stat,
	output logic       result_valid,
	output addr_t      physical_address,
	output logic [1:0] outcome,
	output count_t     access_total,
	output count_t     hit_total,
	output count_t     fault_total
);

	frame_t  map_mem [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] mapped_q;
	lookup_t item_s1;
	logic    valid_s1;
	logic    mapped_s1;
	frame_t  rd_s1;
	frame_t  free_q;
	frame_t  frame_x;
	outcome_t outcome_x;
	addr_t   phys_q;
	outcome_t outcome_q;
	logic    result_valid_q;
	count_t  access_q;
	count_t  hit_q;
	count_t  fault_q;

	assign pop = !empty && !valid_s1;

	always_comb begin
		priority if (item_s1.tlb_hit) begin
			frame_x   = item_s1.frame;
			outcome_x = OUT_TLB_HIT;
		end else if (mapped_s1) begin
			frame_x   = rd_s1;
			outcome_x = OUT_TABLE_HIT;
		end else begin
			frame_x   = free_q;
			outcome_x = OUT_FAULT;
		end
	end

	always_comb begin
		stat.done    = valid_s1;
		stat.fill_en = valid_s1 && !item_s1.tlb_hit;
		stat.page    = item_s1.page;
		stat.frame   = frame_x;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && outcome_x == OUT_FAULT) begin
			map_mem[item_s1.page] <= frame_x;
		end
		if (pop) begin
			rd_s1 <= map_mem[pop_data.page];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1   <= pop_data;
			mapped_s1 <= mapped_q[pop_data.page];
		end
		if (valid_s1) begin
			phys_q    <= phys_addr(frame_x, item_s1.offset);
			outcome_q <= outcome_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			mapped_q       <= '0;
			free_q         <= '0;
			access_q       <= '0;
			hit_q          <= '0;
			fault_q        <= '0;
		end else begin
			valid_s1       <= pop;
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				access_q <= sat_inc(access_q);
				unique case (outcome_x)
					OUT_TLB_HIT: begin
						hit_q <= sat_inc(hit_q);
					end
					OUT_FAULT: begin
						fault_q                <= sat_inc(fault_q);
						mapped_q[item_s1.page] <= 1'b1;
						free_q <= (free_q == frame_t'(FRAME_COUNT - 1)) ?
							'0 : free_q + frame_t'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign result_valid     = result_valid_q;
	assign physical_address = phys_q;
	assign outcome          = outcome_q;
	assign access_total     = access_q;
	assign hit_total        = hit_q;
	assign fault_total      = fault_q;

endmodule

[rtl/core/tlb_page_table_translator.sv]
// ----------------------------------------------------------------------------
// TLB page table translator
// Demand-paging address translation: TLB search, page table read, frame
// allocation on a page fault and saturating access, hit and fault counts.
//
//   channel   handshake            payload
//   --------  -------------------  -----------------------------------------
//   command   start / busy         logical_address
//   result    result_valid strobe  physical_address, outcome, access_total,
//                                  hit_total, fault_total
//
// An address is taken when start is high and busy is low; it then passes
// through the queue, the registered page table read and the result register,
// and its result beat lasts one cycle.
// Busy stays high from the accept until the result beat, so one address is
// in flight at a time: the next address is not taken before the result beat
// is driven. The receiver cannot stall.
// Reset clears the TLB valid bits, the page table mapped bits, the replace
// pointer, the free frame pointer and all counts.
// ----------------------------------------------------------------------------
module tlb_page_table_translator
	import tpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  addr_t      logical_address,
	output logic       result_valid,
	output addr_t      physical_address,
	output logic [1:0] outcome,
	output count_t     access_total,
	output count_t     hit_total,
	output count_t     fault_total
);

	logic       push;
	lookup_t    push_data;
	logic       pop;
	lookup_t    pop_data;
	logic       empty;
	back_stat_t stat;

	tpt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.logical_address (logical_address),
		.push            (push),
		.push_data       (push_data),
		.stat            (stat)
	);

	tpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	tpt_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_data         (pop_data),
		.empty            (empty),
		.pop              (pop),
		.stat             (stat),
		.result_valid     (result_valid),
		.physical_address (physical_address),
		.outcome          (outcome),
		.access_total     (access_total),
		.hit_total        (hit_total),
		.fault_total      (fault_total)
	);

endmodule
